// File: rtl/hrn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harris response NMS package
// Shared constants, types and codes for the Harris response and NMS stream.
// ----------------------------------------------------------------------------
package hrn_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 4;
  localparam int LINE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AW     = $clog2(LINE_DEPTH);
  localparam int PW     = $clog2(LINE_DEPTH + 1);
  localparam int XW     = 10;
  localparam int DIM_W  = 11;
  localparam int RAD_W  = 3;
  localparam int GAIN_W = 16;
  localparam int RESP_W = 56;
  localparam int IDX_W  = 3;
  localparam int DAT_W  = 56;
  localparam int OW     = DIM_W + 1;
  localparam int SW     = $clog2(MAX_RADIUS + 1) + 1;

  localparam logic signed [RESP_W-1:0] SUPPRESSED = -56'sd65535934464;

  typedef enum logic [IDX_W-1:0] {
    CFG_WIDTH     = 3'd0,
    CFG_HEIGHT    = 3'd1,
    CFG_RADIUS    = 3'd2,
    CFG_ALPHA     = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_CHECK, ST_PREP, ST_SCAN, ST_DRAIN, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [23:0]        sxx;
    logic [23:0]        syy;
    logic signed [23:0] sxy;
  } pix_t;

  typedef struct packed {
    logic                     valid;
    logic signed [RESP_W-1:0] value;
  } resp_t;
endpackage

// File: rtl/hrn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harris response NMS channels
// Valid/ready channels for pixels, results and configuration writes.
// ----------------------------------------------------------------------------
interface hrn_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [23:0]        sxx;
  logic [23:0]        syy;
  logic signed [23:0] sxy;
  modport source (output valid, kind, sxx, syy, sxy, input ready);
  modport sink   (input valid, kind, sxx, syy, sxy, output ready);
endinterface

interface hrn_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         pixel_x;
  logic [9:0]         pixel_y;
  logic signed [55:0] nms_response;
  logic               is_corner;
  logic               last;
  modport source (output valid, pixel_x, pixel_y, nms_response, is_corner, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, nms_response, is_corner, last,
                  output ready);
endinterface

interface hrn_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [55:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/hrn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harris response NMS line store
// Synchronous RAM with one write port and one read port; the read is registered.
// ----------------------------------------------------------------------------
module hrn_ram #(
  parameter int DEPTH = 9216,
  parameter int WIDTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/hrn_resp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harris response unit
// Three-stage pipeline computing det - alpha * trace^2 in signed Q.16.
// ----------------------------------------------------------------------------
module hrn_resp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  hrn_pkg::pix_t               pix,
  input  logic [hrn_pkg::GAIN_W-1:0]  alpha,
  output hrn_pkg::resp_t              resp
);
  import hrn_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic [47:0]        pxy_r;
  logic signed [47:0] pcross_r;
  logic [49:0]        t2_r;
  logic signed [49:0] det_r;
  logic [49:0]        ahi_r;
  logic [31:0]        alo_r;
  logic signed [RESP_W-1:0] value_r;
  logic [24:0]        tr;
  logic [50:0]        weighted;

  assign tr       = {1'b0, pix.sxx} + {1'b0, pix.syy};
  assign weighted = {1'b0, ahi_r} + {35'd0, alo_r[31:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    pxy_r    <= pix.sxx * pix.syy;
    pcross_r <= pix.sxy * pix.sxy;
    t2_r     <= tr * tr;
    det_r    <= $signed({2'b00, pxy_r}) - {{2{pcross_r[47]}}, pcross_r};
    ahi_r    <= alpha * t2_r[49:16];
    alo_r    <= alpha * t2_r[15:0];
    value_r  <= {{(RESP_W-50){det_r[49]}}, det_r} - $signed({5'd0, weighted});
  end

  assign resp.valid = v3_r;
  assign resp.value = value_r;
endmodule

// File: rtl/harris_response_nms_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harris response stream with non-maximum suppression
// Computes per-pixel responses, keeps them in a line store and scans the
// suppression window through one memory read port per cycle.
// ----------------------------------------------------------------------------
// A pixel is scored and written to the line store; a flush only checks for output.
// A result then scans the window, one position per read through the single read
// port, and is registered for the output channel.
// One transaction is in work at a time; a waiting result blocks input only once the next result is ready to emit.
// Synchronous active-low reset clears counters and control and loads the
// register defaults; the line store is not cleared.
module harris_response_nms_stream_core (
  input logic      clk,
  input logic      rst_n,
  hrn_in_if.sink   in_ch,
  hrn_out_if.source out_ch,
  hrn_cfg_if.sink  cfg_ch
);
  import hrn_pkg::*;

  localparam logic [AW:0] DEPTH_X = (AW+1)'(LINE_DEPTH);

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]  fw_r, fh_r;
  logic [RAD_W-1:0]  rad_r;
  logic [GAIN_W-1:0] alpha_r;
  logic signed [RESP_W-1:0] thr_r;

  logic [XW-1:0] in_col_r, in_row_r, out_col_r, out_row_r;
  logic [AW-1:0] wr_ptr_r, base_r, addr_r, row_addr_r;
  logic [PW-1:0] pending_r;
  logic signed [SW-1:0] dx_r, dy_r;
  logic          cen_pend_r, cmp_pend_r, sup_r;
  logic signed [RESP_W-1:0] center_r;
  resp_t         resp;
  logic [RESP_W-1:0] rd_data;

  logic          out_valid_r;
  logic [XW-1:0] out_x_r, out_y_r;
  logic signed [RESP_W-1:0] out_resp_r;
  logic          out_corner_r, out_last_r;

  // Effective geometry.
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [RAD_W-1:0] r_eff;
  always_comb begin
    w_eff = (fw_r == '0) ? DIM_W'(1) :
            (fw_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_r;
    h_eff = (fh_r == '0) ? DIM_W'(1) :
            (fh_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_r;
    r_eff = (rad_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_r;
  end

  // Configuration writes.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= DIM_W'(1024);
      fh_r    <= DIM_W'(1024);
      rad_r   <= RAD_W'(3);
      alpha_r <= GAIN_W'(3932);
      thr_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_WIDTH:     fw_r    <= cfg_ch.data[DIM_W-1:0];
        CFG_HEIGHT:    fh_r    <= cfg_ch.data[DIM_W-1:0];
        CFG_RADIUS:    rad_r   <= cfg_ch.data[RAD_W-1:0];
        CFG_ALPHA:     alpha_r <= cfg_ch.data[GAIN_W-1:0];
        CFG_THRESHOLD: thr_r   <= $signed(cfg_ch.data[RESP_W-1:0]);
        default: ;
      endcase
    end
  end

  hrn_resp u_resp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_ch.valid && in_ch.ready && !in_ch.kind),
    .pix   ({in_ch.sxx, in_ch.syy, in_ch.sxy}),
    .alpha (alpha_r),
    .resp  (resp)
  );

  // Readiness of the next output position.
  logic [DIM_W-1:0] need_x, need_y, sum_x, sum_y;
  logic signed [OW-1:0] dxv, dyv;
  logic signed [2*OW-1:0] gap;
  logic out_ready_c;
  always_comb begin
    sum_x  = {1'b0, out_col_r} + DIM_W'(r_eff);
    sum_y  = {1'b0, out_row_r} + DIM_W'(r_eff);
    need_x = (sum_x < w_eff - 1'b1) ? sum_x : w_eff - 1'b1;
    need_y = (sum_y < h_eff - 1'b1) ? sum_y : h_eff - 1'b1;
    dxv    = $signed({1'b0, need_x}) - $signed({2'b00, out_col_r});
    dyv    = $signed({1'b0, need_y}) - $signed({2'b00, out_row_r});
    gap    = dyv * $signed({1'b0, w_eff}) + (2*OW)'(dxv);
    if (gap < 0) begin
      out_ready_c = (pending_r != '0);
    end else begin
      out_ready_c = $signed({{(2*OW-PW){1'b0}}, pending_r}) > gap;
    end
  end

  // Address arithmetic for the window scan.
  logic [AW:0] base_c, start_c, addr_inc, row_inc;
  logic [AW:0] rw_c;
  always_comb begin
    base_c   = {1'b0, wr_ptr_r} + DEPTH_X - (AW+1)'(pending_r);
    if (base_c >= DEPTH_X) base_c = base_c - DEPTH_X;
    rw_c     = (AW+1)'(r_eff) * (AW+1)'(w_eff) + (AW+1)'(r_eff);
    start_c  = {1'b0, base_r} + DEPTH_X - rw_c;
    if (start_c >= DEPTH_X) start_c = start_c - DEPTH_X;
    addr_inc = {1'b0, addr_r} + 1'b1;
    if (addr_inc >= DEPTH_X) addr_inc = '0;
    row_inc  = {1'b0, row_addr_r} + (AW+1)'(w_eff);
    if (row_inc >= DEPTH_X) row_inc = row_inc - DEPTH_X;
  end

  logic signed [OW-1:0] nx, ny;
  logic in_img;
  always_comb begin
    nx = $signed({2'b00, out_col_r}) + OW'(dx_r);
    ny = $signed({2'b00, out_row_r}) + OW'(dy_r);
    in_img = (nx >= 0) && (nx < $signed({1'b0, w_eff})) &&
             (ny >= 0) && (ny < $signed({1'b0, h_eff}));
  end

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  assign rd_addr = (state_r == ST_PREP) ? base_r : addr_r;
  assign wr_en   = (state_r == ST_MUL) && resp.valid;

  hrn_ram #(.DEPTH(LINE_DEPTH), .WIDTH(RESP_W)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ptr_r),
    .wdata (resp.value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  logic emit_go;
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = in_ch.kind ? ST_CHECK : ST_MUL;
      ST_MUL:   if (resp.valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = out_ready_c ? ST_PREP : ST_IDLE;
      ST_PREP:  state_nxt = ST_SCAN;
      ST_SCAN:  if (dx_r == SW'(r_eff) && dy_r == SW'(r_eff)) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  logic [DIM_W-1:0] ic_inc, ir_inc, oc_inc, or_inc;
  assign ic_inc = {1'b0, in_col_r} + 1'b1;
  assign ir_inc = {1'b0, in_row_r} + 1'b1;
  assign oc_inc = {1'b0, out_col_r} + 1'b1;
  assign or_inc = {1'b0, out_row_r} + 1'b1;

  logic signed [RESP_W-1:0] result_c;
  assign result_c = sup_r ? SUPPRESSED : center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      wr_ptr_r    <= '0;
      pending_r   <= '0;
      cen_pend_r  <= 1'b0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cen_pend_r <= (state_r == ST_PREP);
      cmp_pend_r <= (state_r == ST_SCAN) && in_img;
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == AW'(LINE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
        if (pending_r < PW'(LINE_DEPTH)) pending_r <= pending_r + 1'b1;
        if (ic_inc >= w_eff) begin
          in_col_r <= '0;
          in_row_r <= (ir_inc >= h_eff) ? '0 : ir_inc[XW-1:0];
        end else begin
          in_col_r <= ic_inc[XW-1:0];
        end
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
        pending_r   <= pending_r - 1'b1;
        if (oc_inc >= w_eff) begin
          out_col_r <= '0;
          out_row_r <= (or_inc >= h_eff) ? '0 : or_inc[XW-1:0];
        end else begin
          out_col_r <= oc_inc[XW-1:0];
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan datapath; none of it needs a reset.
  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) base_r <= base_c[AW-1:0];
    if (state_r == ST_PREP) begin
      addr_r     <= start_c[AW-1:0];
      row_addr_r <= start_c[AW-1:0];
      dx_r       <= -$signed({{(SW-RAD_W){1'b0}}, r_eff});
      dy_r       <= -$signed({{(SW-RAD_W){1'b0}}, r_eff});
      sup_r      <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      if (dx_r == SW'(r_eff)) begin
        dx_r       <= -$signed({{(SW-RAD_W){1'b0}}, r_eff});
        dy_r       <= dy_r + 1'b1;
        addr_r     <= row_inc[AW-1:0];
        row_addr_r <= row_inc[AW-1:0];
      end else begin
        dx_r   <= dx_r + 1'b1;
        addr_r <= addr_inc[AW-1:0];
      end
    end
    if (cen_pend_r) center_r <= $signed(rd_data);
    if (cmp_pend_r && ($signed(rd_data) > center_r)) sup_r <= 1'b1;
    if (emit_go) begin
      out_x_r      <= out_col_r;
      out_y_r      <= out_row_r;
      out_resp_r   <= result_c;
      out_corner_r <= result_c > thr_r;
      out_last_r   <= ({1'b0, out_col_r} == w_eff - 1'b1) &&
                      ({1'b0, out_row_r} == h_eff - 1'b1);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = out_x_r;
  assign out_ch.pixel_y      = out_y_r;
  assign out_ch.nms_response = out_resp_r;
  assign out_ch.is_corner    = out_corner_r;
  assign out_ch.last         = out_last_r;
endmodule

// File: rtl/hrn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harris response NMS port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module hrn_port_props (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  // A result waiting for the sink is held until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before it was taken");

  // Input work is one transaction at a time.
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is still in work");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid directly after reset");
endmodule

bind harris_response_nms_stream_core hrn_port_props u_hrn_port_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

// File: sim/hrn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harris response NMS checker
// Watches the pixel, result and configuration channels, predicts each result
// from its own copy of the line store and compares it field by field.
// ----------------------------------------------------------------------------
module hrn_checker (
  input  logic clk,
  input  logic rst_n,
  hrn_in_if    in_mon,
  hrn_out_if   out_mon,
  hrn_cfg_if   cfg_mon,
  output int   fail_count,
  output int   awaited_results
);
  import hrn_pkg::*;

  typedef struct {
    logic [9:0]         px;
    logic [9:0]         py;
    logic signed [55:0] resp;
    logic               corner;
    logic               last;
  } nms_result_t;

  nms_result_t nms_expected[$];

  longint          resp_store[LINE_DEPTH];
  int              wr_ptr, backlog;
  int              in_col, in_row, out_col, out_row;
  int              width_reg, height_reg, radius_reg;
  longint unsigned gain_reg;
  longint          thresh_reg;

  assign awaited_results = nms_expected.size();

  function automatic longint harris_resp(logic [23:0] a, logic [23:0] b,
                                         logic signed [23:0] c);
    longint unsigned ua, ub, tr, t2, wgt;
    longint          det, cc;
    ua  = 64'(a);
    ub  = 64'(b);
    cc  = longint'(c);
    det = longint'(ua * ub) - cc * cc;
    tr  = ua + ub;
    t2  = tr * tr;
    // alpha*trace^2 in Q.32, truncated back to Q.16 in two halves.
    wgt = gain_reg * (t2 >> 16) + ((gain_reg * (t2 & 64'hFFFF)) >> 16);
    return det - longint'(wgt);
  endfunction

  function automatic longint stored_back(int back);
    int s;
    s = (wr_ptr - back) % LINE_DEPTH;
    if (s < 0) s += LINE_DEPTH;
    return resp_store[s];
  endfunction

  task automatic predict_window(logic kind, logic [23:0] a, logic [23:0] b,
                                logic signed [23:0] c);
    int          w, h, r, nx, ny, gap;
    longint      centre, res;
    bit          supp;
    nms_result_t e;
    w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    if (!kind) begin
      resp_store[wr_ptr] = harris_resp(a, b, c);
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      if (backlog < LINE_DEPTH) backlog++;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
    end
    nx = (out_col + r < w - 1) ? out_col + r : w - 1;
    ny = (out_row + r < h - 1) ? out_row + r : h - 1;
    gap = ny * w + nx - (out_row * w + out_col);
    if (gap < 0) gap = 0;
    if (backlog <= gap) return;
    centre = stored_back(backlog);
    supp = 0;
    for (int dy = -r; dy <= r; dy++) begin
      if (out_row + dy < 0 || out_row + dy >= h) continue;
      for (int dx = -r; dx <= r; dx++) begin
        if (out_col + dx < 0 || out_col + dx >= w) continue;
        if (stored_back(backlog - (dy * w + dx)) > centre) supp = 1;
      end
    end
    res = supp ? longint'(SUPPRESSED) : centre;
    e.px     = out_col[9:0];
    e.py     = out_row[9:0];
    e.resp   = res[55:0];
    e.corner = res > thresh_reg;
    e.last   = (out_col == w - 1) && (out_row == h - 1);
    nms_expected.push_back(e);
    backlog--;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
  endtask

  always @(posedge clk) begin
    nms_result_t e;
    if (!rst_n) begin
      nms_expected.delete();
      wr_ptr = 0; backlog = 0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      width_reg = 1024; height_reg = 1024; radius_reg = 3;
      gain_reg = 3932; thresh_reg = 0;
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (nms_expected.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d resp=%0d", $time,
                   out_mon.pixel_x, out_mon.pixel_y, out_mon.nms_response);
          fail_count++;
        end else begin
          e = nms_expected.pop_front();
          if (out_mon.pixel_x !== e.px || out_mon.pixel_y !== e.py ||
              out_mon.nms_response !== e.resp || out_mon.is_corner !== e.corner ||
              out_mon.last !== e.last) begin
            $display("%0t: mismatch expected x=%0d y=%0d resp=%0d corner=%0b last=%0b",
                     $time, e.px, e.py, e.resp, e.corner, e.last);
            $display("%0t:          actual   x=%0d y=%0d resp=%0d corner=%0b last=%0b",
                     $time, out_mon.pixel_x, out_mon.pixel_y, out_mon.nms_response,
                     out_mon.is_corner, out_mon.last);
            fail_count++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_WIDTH:     width_reg  = int'(cfg_mon.data[10:0]);
          CFG_HEIGHT:    height_reg = int'(cfg_mon.data[10:0]);
          CFG_RADIUS:    radius_reg = int'(cfg_mon.data[2:0]);
          CFG_ALPHA:     gain_reg   = 64'(cfg_mon.data[15:0]);
          CFG_THRESHOLD: thresh_reg = longint'($signed(cfg_mon.data));
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_window(in_mon.kind, in_mon.sxx, in_mon.syy, in_mon.sxy);
    end
  end
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harris response NMS testbench
// Drives whole frames of structure-matrix pixels under several geometries,
// gains and thresholds, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import hrn_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  bit   calm = 0;
  int   fail_count, awaited_results, item_total;

  hrn_in_if  in_ch();
  hrn_out_if out_ch();
  hrn_cfg_if cfg_ch();

  harris_response_nms_stream_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  hrn_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .awaited_results(awaited_results)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 27);
  end

  task automatic send_item(logic kind, logic [23:0] a, logic [23:0] b,
                           logic signed [23:0] c);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 27) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.kind  = kind;
    in_ch.sxx   = a;
    in_ch.syy   = b;
    in_ch.sxy   = c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    item_total++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [55:0] value);
    @(negedge clk);
    in_ch.valid  = 0;
    cfg_ch.valid = 1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  // Waits for every expected result, then for the longest window scan.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 0;
    while (awaited_results != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_geometry(int w, int h, int r, int a, longint t);
    write_reg(CFG_WIDTH, 56'(w));
    write_reg(CFG_HEIGHT, 56'(h));
    write_reg(CFG_RADIUS, 56'(r));
    write_reg(CFG_ALPHA, 56'(a));
    write_reg(CFG_THRESHOLD, t[55:0]);
  endtask

  task automatic random_pixel(bit tie_heavy);
    logic [23:0] a, b;
    logic signed [23:0] c;
    if (tie_heavy) begin
      // A small value set makes equal neighbours frequent.
      a = 24'($urandom_range(3) << 8);
      b = 24'($urandom_range(3) << 8);
      c = $signed(24'($urandom_range(2))) - 24'sd1;
    end else begin
      a = 24'($urandom);
      b = 24'($urandom);
      c = 24'($urandom);
    end
    send_item(0, a, b, c);
  endtask

  // Sends whole frames with some stray flushes, then enough flushes to drain.
  task automatic run_frames(int w, int h, int r, int a, longint t, int frames);
    int ew, eh, er;
    bit ties;
    set_geometry(w, h, r, a, t);
    ew = (w < 1) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
    eh = (h < 1) ? 1 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
    er = (r > MAX_RADIUS) ? MAX_RADIUS : r;
    for (int f = 0; f < frames; f++) begin
      ties = $urandom_range(1);
      for (int p = 0; p < ew * eh; p++) begin
        if ($urandom_range(19) == 0)
          send_item(1, 24'($urandom), 24'($urandom), 24'($urandom));
        random_pixel(ties);
      end
    end
    for (int k = 0; k < er * ew + er + 1; k++)
      send_item(1, 24'($urandom), 24'($urandom), 24'($urandom));
    wait_idle();
  endtask

  task automatic directed_frame();
    logic [23:0] sx[20] = '{0, 24'hFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 24'h000100,
                            24'h000100, 24'h000100, 24'hABCDEF, 24'h000100, 24'h000100,
                            24'h800000, 1, 24'h7FFFFF, 24'h000100, 24'h123456, 2, 0};
    logic [23:0] sy[20] = '{0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 24'h000100,
                            24'h000100, 24'h000100, 24'h0F0F0F, 24'h000100, 24'h000100,
                            24'h000001, 1, 24'h800000, 24'h000100, 24'h654321, 2, 0};
    logic signed [23:0] sc[20] = '{0, 0, 0, -24'sd8388608, 24'sd8388607, -24'sd8388608,
                                   24'sd8388607, 0, 0, 0, -24'sd5, 0, 0, 24'sd100, -24'sd1,
                                   24'sd1, 0, 24'sd123, -24'sd2, 0};
    set_geometry(5, 4, 1, 3932, 0);
    send_item(1, 0, 0, 0);
    for (int i = 0; i < 20; i++) begin
      send_item(0, sx[i], sy[i], sc[i]);
      if (i == 9) send_item(1, 24'hFFFFFF, 24'hFFFFFF, -1);
    end
    for (int k = 0; k < 8; k++) send_item(1, 0, 0, 0);
    wait_idle();
  endtask

  initial begin
    int rw, rh, rr, ra;
    longint rt;
    in_ch.valid = 0; in_ch.kind = 0; in_ch.sxx = 0; in_ch.syy = 0; in_ch.sxy = 0;
    cfg_ch.valid = 0; cfg_ch.index = CFG_WIDTH; cfg_ch.data = 0;
    item_total = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;
    directed_frame();
    run_frames(1, 1, 7, 0, -56'sd36028797018963968, 2);
    run_frames(0, 3, 4, 65535, 56'sd36028797018963967, 1);
    run_frames(4, 0, 2, 65535, -56'sd65535934464, 1);
    while (item_total < 1050) begin
      calm = (item_total >= 400 && item_total < 600);
      rw = $urandom_range(1, 12);
      rh = $urandom_range(1, 8);
      rr = $urandom_range(7);
      case ($urandom_range(3))
        0: ra = 0;
        1: ra = 65535;
        default: ra = $urandom_range(65535);
      endcase
      case ($urandom_range(3))
        0: rt = 0;
        1: rt = longint'($signed(56'({$urandom, $urandom})));
        default: rt = $signed(32'($urandom)) >>> $urandom_range(31);
      endcase
      run_frames(rw, rh, rr, ra, rt, $urandom_range(1, 3));
    end
    calm = 0;
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: sim.f
rtl/hrn_pkg.sv
rtl/hrn_if.sv
rtl/hrn_ram.sv
rtl/hrn_resp.sv
rtl/harris_response_nms_stream_core.sv
rtl/hrn_checker.sv
sim/hrn_checker.sv
sim/tb_top.sv
